// ----- rtl/pwlc_pkg.sv -----
// ----------------------------------------------------------------------------
// pwlc_pkg
// Shared types and constants for the power window lift controller.
// ----------------------------------------------------------------------------
package pwlc_pkg;

  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_MUP   = 3'd1,
    MODE_MDOWN = 3'd2,
    MODE_AUP   = 3'd3,
    MODE_ADOWN = 3'd4,
    MODE_REV   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    CMD_STOP = 2'd0,
    CMD_UP   = 2'd1,
    CMD_DOWN = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_MIN  = 2'd0,
    CFG_AUTO_MAX  = 2'd1,
    CFG_REV_TICKS = 2'd2
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] AUTO_MIN_RST  = 16'd10000;
  localparam logic [CFG_W-1:0] AUTO_MAX_RST  = 16'd20000;
  localparam logic [CFG_W-1:0] REV_TICKS_RST = 16'd500;

  typedef struct packed {
    logic driver_up;
    logic driver_down;
    logic passenger_up;
    logic passenger_down;
    logic lock_on;
    logic obstacle;
    logic top_limit;
    logic bottom_limit;
  } sample_t;

  typedef struct packed {
    logic [CFG_W-1:0] auto_min_count;
    logic [CFG_W-1:0] auto_max_count;
    logic [CFG_W-1:0] reverse_ticks;
  } cfg_t;

endpackage

// ----- rtl/pwlc_fsm.sv -----
// ----------------------------------------------------------------------------
// pwlc_fsm
// Mode state machine with press counter and reversal timer; state advances
// once per sample when advance is high.
// ----------------------------------------------------------------------------
module pwlc_fsm #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  pwlc_pkg::sample_t sample,
  input  pwlc_pkg::cfg_t    cfg,
  output pwlc_pkg::cmd_t    cmd,
  output pwlc_pkg::mode_t   mode_nxt
);
  import pwlc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  mode_t                  mode_r;
  logic [COUNT_WIDTH-1:0] press_r, press_nxt;
  logic [CFG_W-1:0]       rev_r, rev_nxt;

  logic             req_up, req_dn;
  logic             auto_ok;
  logic [CMP_W-1:0] press_ext, min_ext, max_ext;
  logic [CFG_W-1:0] rev_load, rev_dec;
  logic [COUNT_WIDTH-1:0] press_inc;

  assign req_up    = sample.driver_up | (~sample.lock_on & sample.passenger_up);
  assign req_dn    = sample.driver_down | (~sample.lock_on & sample.passenger_down);
  assign press_ext = CMP_W'(press_r);
  assign min_ext   = CMP_W'(cfg.auto_min_count);
  assign max_ext   = CMP_W'(cfg.auto_max_count);
  assign auto_ok   = (press_ext > min_ext) && (press_ext < max_ext);
  assign rev_load  = (cfg.reverse_ticks == '0) ? CFG_W'(1) : cfg.reverse_ticks;
  assign rev_dec   = rev_r - CFG_W'(1);
  assign press_inc = (press_r != CNT_MAX) ? press_r + CNT_ONE : press_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      press_r <= '0;
      rev_r   <= '0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      press_r <= press_nxt;
      rev_r   <= rev_nxt;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    press_nxt = press_r;
    rev_nxt   = rev_r;
    cmd       = CMD_STOP;
    unique case (mode_r)
      MODE_REV: begin
        rev_nxt = rev_dec;
        if (rev_dec == '0) begin
          mode_nxt = MODE_IDLE;
        end else begin
          cmd = CMD_DOWN;
        end
      end
      MODE_MUP: begin
        if (sample.obstacle) begin
          mode_nxt  = MODE_REV;
          press_nxt = '0;
          rev_nxt   = rev_load;
          cmd       = CMD_DOWN;
        end else if (req_up) begin
          press_nxt = press_inc;
          cmd       = sample.top_limit ? CMD_STOP : CMD_UP;
        end else begin
          press_nxt = '0;
          if (auto_ok && !sample.top_limit) begin
            mode_nxt = MODE_AUP;
            cmd      = CMD_UP;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
      end
      MODE_MDOWN: begin
        if (req_dn) begin
          press_nxt = press_inc;
          cmd       = sample.bottom_limit ? CMD_STOP : CMD_DOWN;
        end else begin
          press_nxt = '0;
          if (auto_ok && !sample.bottom_limit) begin
            mode_nxt = MODE_ADOWN;
            cmd      = CMD_DOWN;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
      end
      MODE_AUP: begin
        if (sample.obstacle) begin
          mode_nxt  = MODE_REV;
          press_nxt = '0;
          rev_nxt   = rev_load;
          cmd       = CMD_DOWN;
        end else if (sample.top_limit || sample.driver_down || sample.passenger_down) begin
          mode_nxt = MODE_IDLE;
        end else begin
          cmd = CMD_UP;
        end
      end
      MODE_ADOWN: begin
        if (sample.bottom_limit || sample.driver_up || sample.passenger_up) begin
          mode_nxt = MODE_IDLE;
        end else begin
          cmd = CMD_DOWN;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        if (req_dn) begin
          mode_nxt  = MODE_MDOWN;
          press_nxt = CNT_ONE;
          cmd       = sample.bottom_limit ? CMD_STOP : CMD_DOWN;
        end else if (req_up) begin
          if (sample.obstacle) begin
            mode_nxt  = MODE_REV;
            press_nxt = '0;
            rev_nxt   = rev_load;
            cmd       = CMD_DOWN;
          end else begin
            mode_nxt  = MODE_MUP;
            press_nxt = CNT_ONE;
            cmd       = sample.top_limit ? CMD_STOP : CMD_UP;
          end
        end
      end
    endcase
  end

endmodule

// ----- rtl/power_window_lift_controller_core.sv -----
// ----------------------------------------------------------------------------
// power_window_lift_controller_core
// Window lift controller: switch samples in, motor command and mode out.
//
//   channel  ports                              handshake
//   in       in_driver_up .. in_bottom_limit    in_valid / in_ready
//   out      out_motor_cmd, out_mode_now        out_valid / out_ready
//   cfg      cfg_index, cfg_wdata               cfg_we, no wait
//
// one word per cycle sustained; an accepted word sits in the input register
// and the state machine step loads the result register once the output is
// free, i.e. the result register is empty or out_ready is high. state
// updates only when a word moves from the input register to the result
// register. a stalled output holds the result register, and in_ready drops
// once the input register is also full. synchronous active-low reset.
// ----------------------------------------------------------------------------
module power_window_lift_controller_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_driver_up,
  input  logic                           in_driver_down,
  input  logic                           in_passenger_up,
  input  logic                           in_passenger_down,
  input  logic                           in_lock_on,
  input  logic                           in_obstacle,
  input  logic                           in_top_limit,
  input  logic                           in_bottom_limit,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_motor_cmd,
  output logic [2:0]                     out_mode_now,
  input  logic                           cfg_we,
  input  logic [pwlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pwlc_pkg::CFG_W-1:0]     cfg_wdata
);
  import pwlc_pkg::*;

  cfg_t    cfg_r;
  sample_t smp_r;
  logic    smp_valid_r;
  logic    out_valid_r;
  cmd_t    cmd_r;
  mode_t   mode_out_r;

  cmd_t    cmd;
  mode_t   mode_nxt;
  logic    out_free, advance;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = smp_valid_r && out_free;
  assign in_ready = !smp_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_min_count <= AUTO_MIN_RST;
      cfg_r.auto_max_count <= AUTO_MAX_RST;
      cfg_r.reverse_ticks  <= REV_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUTO_MIN:  cfg_r.auto_min_count <= cfg_wdata;
        CFG_AUTO_MAX:  cfg_r.auto_max_count <= cfg_wdata;
        CFG_REV_TICKS: cfg_r.reverse_ticks  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        smp_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= smp_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r.driver_up      <= in_driver_up;
      smp_r.driver_down    <= in_driver_down;
      smp_r.passenger_up   <= in_passenger_up;
      smp_r.passenger_down <= in_passenger_down;
      smp_r.lock_on        <= in_lock_on;
      smp_r.obstacle       <= in_obstacle;
      smp_r.top_limit      <= in_top_limit;
      smp_r.bottom_limit   <= in_bottom_limit;
    end
    if (advance) begin
      cmd_r      <= cmd;
      mode_out_r <= mode_nxt;
    end
  end

  pwlc_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .sample   (smp_r),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .mode_nxt (mode_nxt)
  );

  assign out_valid     = out_valid_r;
  assign out_motor_cmd = cmd_r;
  assign out_mode_now  = mode_out_r;

endmodule
